// ----- design/kss_pkg.sv -----
// Shared types, constants and helpers for the keyword sequence spotter.
package kss_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_SLOTS_DEF   = 8;
    localparam int MAX_KEY_LEN_DEF = 16;

    // Token field widths, sized for the largest supported parameters
    localparam int TOK_IDX_W  = 6;   // character position, up to 64 chars
    localparam int TOK_CNT_W  = 7;   // string / keyword length, up to 65
    localparam int TOK_SLOT_W = 6;   // slot number, up to 64 slots

    typedef enum logic [1:0] {
        OP_CHAR     = 2'd0,
        OP_TOGGLE   = 2'd1,
        OP_KEY_CHAR = 2'd2,
        OP_KEY_LEN  = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        CFG_ENABLED_AT_RESET = 1'b0,
        CFG_TOGGLE_ALLOWED   = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED,
        S_WAIT,
        S_EVAL,
        S_RES
    } state_t;

    // One character of the held string travelling down the cell chain.
    // The match verdict rides along and is final on the last token.
    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  last;
        logic [TOK_IDX_W-1:0]  idx;
        logic [7:0]            ch;
        logic [TOK_CNT_W-1:0]  cnt;
        logic                  exact;
        logic                  prefix;
        logic [TOK_SLOT_W-1:0] hit_slot;
    } token_t;

    // Keyword load request, broadcast to every cell
    typedef struct packed {
        logic                  char_we;
        logic                  len_we;
        logic [TOK_SLOT_W-1:0] slot;
        logic [TOK_IDX_W-1:0]  pos;
        logic [7:0]            ch;
        logic [TOK_CNT_W-1:0]  len;
    } key_wr_t;

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'd32;
        end
        return r;
    endfunction

endpackage

// ----- design/kss_cell.sv -----
// One keyword slot: stores a keyword and checks the passing held string against it.
module kss_cell #(
    parameter int MAX_KEY_LEN = kss_pkg::MAX_KEY_LEN_DEF,
    parameter int SLOT_ID     = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  kss_pkg::key_wr_t kw,
    input  kss_pkg::token_t tok_in,
    output kss_pkg::token_t tok_out
);

    localparam int IDX_W = $clog2(MAX_KEY_LEN);
    localparam int LEN_W = $clog2(MAX_KEY_LEN + 1);

    logic [7:0]                      kmem [MAX_KEY_LEN];
    logic [7:0]                      kdata_reg;
    logic [LEN_W-1:0]                len_reg;
    logic                            same_reg;
    logic                            same_next;
    kss_pkg::token_t                 tok_a_reg;
    kss_pkg::token_t                 tok_out_reg;
    kss_pkg::token_t                 tok_out_next;
    logic                            sel;
    logic [kss_pkg::TOK_CNT_W-1:0]   len_ext;
    logic                            own_ok;
    logic                            own_exact;
    logic                            own_prefix;

    assign sel = (kw.slot == kss_pkg::TOK_SLOT_W'(SLOT_ID));

    // keyword storage, registered read at the token's position
    always_ff @(posedge clk)
    begin
        if (kw.char_we && sel)
        begin
            kmem[kw.pos[IDX_W-1:0]] <= kw.ch;
        end
        kdata_reg <= kmem[tok_in.idx[IDX_W-1:0]];
    end

    always_comb
    begin
        len_ext      = kss_pkg::TOK_CNT_W'(len_reg);
        same_next    = (tok_a_reg.first | same_reg) & (kdata_reg == tok_a_reg.ch);
        own_ok       = same_next && (len_reg != '0) && (tok_a_reg.cnt <= len_ext);
        own_exact    = own_ok && (tok_a_reg.cnt == len_ext);
        own_prefix   = own_ok && (tok_a_reg.cnt != len_ext);
        tok_out_next = tok_a_reg;
        if (tok_a_reg.valid && tok_a_reg.last)
        begin
            // lower slots already passed: an earlier exact hit wins
            if (!tok_a_reg.exact && own_exact)
            begin
                tok_out_next.exact    = 1'b1;
                tok_out_next.hit_slot = kss_pkg::TOK_SLOT_W'(SLOT_ID);
            end
            tok_out_next.prefix = tok_a_reg.prefix | own_prefix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            same_reg    <= 1'b0;
            tok_a_reg   <= '0;
            tok_out_reg <= '0;
        end
        else
        begin
            if (kw.len_we && sel)
            begin
                len_reg <= kw.len[LEN_W-1:0];
            end
            if (tok_a_reg.valid)
            begin
                same_reg <= same_next;
            end
            tok_a_reg   <= tok_in;
            tok_out_reg <= tok_out_next;
        end
    end

    assign tok_out = tok_out_reg;

endmodule

// ----- design/keyword_sequence_spotter.sv -----
// Top level of the keyword sequence spotter: sequencer, held string and cell chain.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: a typed
//   character, a toggle key, a keyword character load or a keyword length load.
//   Every item gives exactly one result transfer on out_valid/out_ready:
//   fired flag and slot, held string length (MAX_KEY_LEN+1 = too long) and
//   the current enable.
//   Config channel (cfg_valid/cfg_ready, always ready) writes enabled_at_reset
//   (also loads the live enable) and toggle_allowed; write only while idle.
// Checking / throughput:
//   Non-checking items go from idle straight to the result state. A checked
//   character streams its held string of n chars through the chain of
//   NUM_SLOTS cells, two register stages per cell, and a collapsed string is
//   checked a second time (n = 1). Items are handled one at a time; in_ready
//   is high only while the sequencer is idle.
// Reset:
//   All slots empty, held string empty, spotting disabled, no result pending.
// Stall:
//   A finished result sits in the output register; a new item can be taken
//   meanwhile, and its result waits until the pending one is transferred.
module keyword_sequence_spotter #(
    parameter int NUM_SLOTS   = kss_pkg::NUM_SLOTS_DEF,
    parameter int MAX_KEY_LEN = kss_pkg::MAX_KEY_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // item input
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [7:0] char_code,
    input  logic       typing_active,
    input  logic [2:0] slot,
    input  logic [3:0] position,
    input  logic [4:0] keyword_length,
    // result output
    output logic       out_valid,
    input  logic       out_ready,
    output logic       fired,
    output logic [2:0] fired_slot,
    output logic [4:0] held_length,
    output logic       spotting_on,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic       cfg_data
);

    localparam int IDX_W = $clog2(MAX_KEY_LEN);
    localparam int CNT_W = $clog2(MAX_KEY_LEN + 2);
    localparam logic [CNT_W-1:0] CNT_MAX      = CNT_W'(MAX_KEY_LEN);
    localparam logic [CNT_W-1:0] CNT_TOO_LONG = CNT_W'(MAX_KEY_LEN + 1);

    // control state
    kss_pkg::state_t state_reg, state_next;
    logic             ena_rst_reg, ena_rst_next;
    logic             tog_ok_reg, tog_ok_next;
    logic             spot_en_reg, spot_en_next;
    logic [CNT_W-1:0] held_cnt_reg, held_cnt_next;
    logic [7:0]       newest_reg, newest_next;
    logic             pass_reg, pass_next;
    logic [IDX_W-1:0] feed_idx_reg, feed_idx_next;
    logic             res_exact_reg, res_exact_next;
    logic             res_prefix_reg, res_prefix_next;
    logic [kss_pkg::TOK_SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic             fired_pend_reg, fired_pend_next;
    logic [kss_pkg::TOK_SLOT_W-1:0] fslot_pend_reg, fslot_pend_next;
    kss_pkg::token_t  issue_reg, issue_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic             fired_reg, fired_next;
    logic [2:0]       fired_slot_reg, fired_slot_next;
    logic [4:0]       held_length_reg, held_length_next;
    logic             spotting_on_reg, spotting_on_next;

    // held string memory
    logic [7:0]       held_mem [MAX_KEY_LEN];
    logic [7:0]       held_rdata_reg;
    logic             held_we;
    logic [IDX_W-1:0] held_waddr;
    logic [7:0]       held_wdata;

    logic [7:0]       ch_fold;
    logic             feed_last;
    logic [kss_pkg::TOK_CNT_W-1:0] klen_ext;
    logic [kss_pkg::TOK_CNT_W-1:0] held_cnt_wide;
    kss_pkg::key_wr_t kw;
    kss_pkg::token_t  chain_in;
    kss_pkg::token_t  links [NUM_SLOTS+1];

    assign ch_fold   = kss_pkg::fold_upper(char_code);
    assign klen_ext  = kss_pkg::TOK_CNT_W'(keyword_length);
    assign feed_last = ((CNT_W'(feed_idx_reg) + CNT_W'(1)) == held_cnt_reg);
    assign held_cnt_wide = kss_pkg::TOK_CNT_W'(held_cnt_reg);

    // keyword load request; range checks here, slot match in the cells
    always_comb
    begin
        kw.slot    = kss_pkg::TOK_SLOT_W'(slot);
        kw.pos     = kss_pkg::TOK_IDX_W'(position);
        kw.ch      = ch_fold;
        kw.len     = (klen_ext > kss_pkg::TOK_CNT_W'(MAX_KEY_LEN))
                     ? kss_pkg::TOK_CNT_W'(MAX_KEY_LEN) : klen_ext;
        kw.char_we = 1'b0;
        kw.len_we  = 1'b0;
        if (state_reg == kss_pkg::S_IDLE && in_valid)
        begin
            if (kss_pkg::op_t'(opcode) == kss_pkg::OP_KEY_CHAR)
            begin
                kw.char_we = (kss_pkg::TOK_CNT_W'(position)
                              < kss_pkg::TOK_CNT_W'(MAX_KEY_LEN));
            end
            if (kss_pkg::op_t'(opcode) == kss_pkg::OP_KEY_LEN)
            begin
                kw.len_we = 1'b1;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        ena_rst_next     = ena_rst_reg;
        tog_ok_next      = tog_ok_reg;
        spot_en_next     = spot_en_reg;
        held_cnt_next    = held_cnt_reg;
        newest_next      = newest_reg;
        pass_next        = pass_reg;
        feed_idx_next    = feed_idx_reg;
        res_exact_next   = res_exact_reg;
        res_prefix_next  = res_prefix_reg;
        res_slot_next    = res_slot_reg;
        fired_pend_next  = fired_pend_reg;
        fslot_pend_next  = fslot_pend_reg;
        issue_next       = '0;
        out_valid_next   = out_valid_reg;
        fired_next       = fired_reg;
        fired_slot_next  = fired_slot_reg;
        held_length_next = held_length_reg;
        spotting_on_next = spotting_on_reg;
        held_we          = 1'b0;
        held_waddr       = '0;
        held_wdata       = newest_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (kss_pkg::cfg_idx_t'(cfg_index))
                kss_pkg::CFG_ENABLED_AT_RESET:
                begin
                    ena_rst_next = cfg_data;
                    spot_en_next = cfg_data;
                end
                kss_pkg::CFG_TOGGLE_ALLOWED:
                begin
                    tog_ok_next = cfg_data;
                end
                default:
                begin
                    tog_ok_next = tog_ok_reg;
                end
            endcase
        end

        unique case (state_reg)
            kss_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    fired_pend_next = 1'b0;
                    fslot_pend_next = '0;
                    state_next      = kss_pkg::S_RES;
                    unique case (kss_pkg::op_t'(opcode))
                        kss_pkg::OP_CHAR:
                        begin
                            if (!typing_active)
                            begin
                                newest_next = ch_fold;
                                if (held_cnt_reg < CNT_MAX)
                                begin
                                    held_we       = 1'b1;
                                    held_waddr    = held_cnt_reg[IDX_W-1:0];
                                    held_wdata    = ch_fold;
                                    held_cnt_next = held_cnt_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    held_cnt_next = CNT_TOO_LONG;
                                end
                                if (spot_en_reg)
                                begin
                                    pass_next = 1'b0;
                                    if (held_cnt_reg < CNT_MAX)
                                    begin
                                        feed_idx_next = '0;
                                        state_next    = kss_pkg::S_FEED;
                                    end
                                    else
                                    begin
                                        // too long: matches nothing, skip the scan
                                        res_exact_next  = 1'b0;
                                        res_prefix_next = 1'b0;
                                        state_next      = kss_pkg::S_EVAL;
                                    end
                                end
                            end
                        end
                        kss_pkg::OP_TOGGLE:
                        begin
                            if (tog_ok_reg)
                            begin
                                spot_en_next = !spot_en_reg;
                            end
                        end
                        kss_pkg::OP_KEY_CHAR,
                        kss_pkg::OP_KEY_LEN:
                        begin
                            // loads are done by the cells through kw
                            newest_next = newest_reg;
                        end
                        default:
                        begin
                            newest_next = newest_reg;
                        end
                    endcase
                end
            end

            kss_pkg::S_FEED:
            begin
                issue_next.valid = 1'b1;
                issue_next.first = (feed_idx_reg == '0);
                issue_next.last  = feed_last;
                issue_next.idx   = kss_pkg::TOK_IDX_W'(feed_idx_reg);
                issue_next.cnt   = held_cnt_wide;
                if (feed_last)
                begin
                    state_next = kss_pkg::S_WAIT;
                end
                else
                begin
                    feed_idx_next = feed_idx_reg + IDX_W'(1);
                end
            end

            kss_pkg::S_WAIT:
            begin
                if (links[NUM_SLOTS].valid && links[NUM_SLOTS].last)
                begin
                    res_exact_next  = links[NUM_SLOTS].exact;
                    res_prefix_next = links[NUM_SLOTS].prefix;
                    res_slot_next   = links[NUM_SLOTS].hit_slot;
                    state_next      = kss_pkg::S_EVAL;
                end
            end

            kss_pkg::S_EVAL:
            begin
                priority if (res_exact_reg)
                begin
                    held_cnt_next   = '0;
                    fired_pend_next = 1'b1;
                    fslot_pend_next = res_slot_reg;
                    state_next      = kss_pkg::S_RES;
                end
                else if (res_prefix_reg)
                begin
                    state_next = kss_pkg::S_RES;
                end
                else if (held_cnt_reg >= CNT_W'(2))
                begin
                    // collapse to the newest character
                    held_we       = 1'b1;
                    held_waddr    = '0;
                    held_wdata    = newest_reg;
                    held_cnt_next = CNT_W'(1);
                    if (!pass_reg)
                    begin
                        pass_next     = 1'b1;
                        feed_idx_next = '0;
                        state_next    = kss_pkg::S_FEED;
                    end
                    else
                    begin
                        state_next = kss_pkg::S_RES;
                    end
                end
                else
                begin
                    held_cnt_next = '0;
                    state_next    = kss_pkg::S_RES;
                end
            end

            kss_pkg::S_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    fired_next       = fired_pend_reg;
                    fired_slot_next  = fslot_pend_reg[2:0];
                    held_length_next = held_cnt_wide[4:0];
                    spotting_on_next = spot_en_reg;
                    state_next       = kss_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = kss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kss_pkg::S_IDLE;
            ena_rst_reg    <= 1'b0;
            tog_ok_reg     <= 1'b0;
            spot_en_reg    <= 1'b0;
            held_cnt_reg   <= '0;
            newest_reg     <= '0;
            pass_reg       <= 1'b0;
            feed_idx_reg   <= '0;
            res_exact_reg  <= 1'b0;
            res_prefix_reg <= 1'b0;
            fired_pend_reg <= 1'b0;
            issue_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ena_rst_reg    <= ena_rst_next;
            tog_ok_reg     <= tog_ok_next;
            spot_en_reg    <= spot_en_next;
            held_cnt_reg   <= held_cnt_next;
            newest_reg     <= newest_next;
            pass_reg       <= pass_next;
            feed_idx_reg   <= feed_idx_next;
            res_exact_reg  <= res_exact_next;
            res_prefix_reg <= res_prefix_next;
            fired_pend_reg <= fired_pend_next;
            issue_reg      <= issue_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_slot_reg    <= res_slot_next;
        fslot_pend_reg  <= fslot_pend_next;
        fired_reg       <= fired_next;
        fired_slot_reg  <= fired_slot_next;
        held_length_reg <= held_length_next;
        spotting_on_reg <= spotting_on_next;
    end

    // held string: one write port, registered read at the feed index
    always_ff @(posedge clk)
    begin
        if (held_we)
        begin
            held_mem[held_waddr] <= held_wdata;
        end
        held_rdata_reg <= held_mem[feed_idx_reg];
    end

    // token entering the chain: issue info plus the character just read
    always_comb
    begin
        chain_in          = issue_reg;
        chain_in.ch       = held_rdata_reg;
        chain_in.exact    = 1'b0;
        chain_in.prefix   = 1'b0;
        chain_in.hit_slot = '0;
    end

    assign links[0] = chain_in;

    for (genvar s = 0; s < NUM_SLOTS; s++)
    begin : g_cell
        kss_cell #(
            .MAX_KEY_LEN (MAX_KEY_LEN),
            .SLOT_ID     (s)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .kw      (kw),
            .tok_in  (links[s]),
            .tok_out (links[s+1])
        );
    end

    assign in_ready    = (state_reg == kss_pkg::S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign fired       = fired_reg;
    assign fired_slot  = fired_slot_reg;
    assign held_length = held_length_reg;
    assign spotting_on = spotting_on_reg;

    // held count never goes past the too-long mark
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg <= CNT_TOO_LONG)
        else $error("held count out of range");

    // a scan only runs over a real, non-saturated string
    a_feed_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kss_pkg::S_FEED |-> (held_cnt_reg != '0 && held_cnt_reg <= CNT_MAX))
        else $error("feeding with bad held count");

    // chain verdict only shows up while the sequencer waits for it
    a_chain_done: assert property (@(posedge clk) disable iff (!rst_n)
        (links[NUM_SLOTS].valid && links[NUM_SLOTS].last) |-> state_reg == kss_pkg::S_WAIT)
        else $error("chain verdict outside wait");

    // a fire clears the held string
    a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fired_reg) |-> held_length_reg == 5'd0)
        else $error("fired with non-empty string");

    // slot is zero whenever nothing fired
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !fired_reg) |-> fired_slot_reg == 3'd0)
        else $error("slot set without fire");

endmodule

// ----- dv/tb_keyword_sequence_spotter.sv -----
// Self-checking testbench for keyword_sequence_spotter: directed and random item streams.
`timescale 1ns / 100ps

module tb_keyword_sequence_spotter;

    localparam int NSLOT         = kss_pkg::NUM_SLOTS_DEF;
    localparam int KEYLEN        = kss_pkg::MAX_KEY_LEN_DEF;
    localparam int TOO_LONG      = KEYLEN + 1;
    localparam int IDLE_PCT      = 26;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // margin after the drain; a collapsed string runs through the chain twice
    localparam int SETTLE_CYCLES = 2 * (KEYLEN + 2 * NSLOT + 3) + 20;

    // outcome of one pass over the keyword slots
    typedef enum int {M_NONE, M_PREFIX, M_EXACT} match_t;

    typedef struct {
        kss_pkg::op_t op;
        logic [7:0]   ch;
        logic         typing;
        logic [2:0]   slot;
        logic [3:0]   pos;
        logic [4:0]   klen;
    } spot_item_t;

    typedef struct packed {
        logic       fired;
        logic [2:0] slot;
        logic [4:0] hlen;
        logic       on;
    } spot_res_t;

    // DUT ports; every input starts at a known value
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] opcode = '0;
    logic [7:0] char_code = '0;
    logic       typing_active = 1'b0;
    logic [2:0] slot = '0;
    logic [3:0] position = '0;
    logic [4:0] keyword_length = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       fired;
    logic [2:0] fired_slot;
    logic [4:0] held_length;
    logic       spotting_on;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_index = '0;
    logic       cfg_data = 1'b0;

    keyword_sequence_spotter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .char_code     (char_code),
        .typing_active (typing_active),
        .slot          (slot),
        .position      (position),
        .keyword_length(keyword_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fired         (fired),
        .fired_slot    (fired_slot),
        .held_length   (held_length),
        .spotting_on   (spotting_on),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Spotter prediction state, updated at each accepted transfer
    // ------------------------------------------------------------------
    logic [7:0]  kw_chars [NSLOT][KEYLEN];
    logic [4:0]  kw_len   [NSLOT];
    logic [7:0]  held     [KEYLEN];
    int unsigned held_n;
    bit          spot_en;
    bit          en_at_reset;
    bit          tog_ok;
    logic [7:0]  last_ch;

    // Stimulus side view of the keywords, so typed words are known ahead of time
    // and no slot ever gets a length that covers an unwritten character.
    logic [7:0]  gen_chars [NSLOT][KEYLEN];
    bit          gen_wr    [NSLOT][KEYLEN];
    int          gen_len   [NSLOT];

    spot_item_t  spot_pending[$];     // items waiting for the driver
    spot_res_t   spot_expected[$];    // predicted results, oldest first
    spot_item_t  cur_item;            // item currently on the input pins
    bit          in_taken = 1'b0;     // input transfer at the last rising edge
    bit          no_gaps = 1'b0;      // both sides run without idling
    int          items_open = 0;      // queued but not yet transferred
    int          items_made = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    // One pass over the slots, lowest first; the first exact match wins.
    function automatic match_t match_held(output logic [2:0] hit);
        match_t verdict;
        bit     same;
        verdict = M_NONE;
        hit = '0;
        for (int s = 0; s < NSLOT; s++)
        begin
            if (kw_len[s] == 0 || held_n > kw_len[s] || held_n > KEYLEN)
                continue;
            same = 1'b1;
            for (int i = 0; i < held_n; i++)
                if (kw_chars[s][i] != held[i])
                    same = 1'b0;
            if (!same)
                continue;
            if (kw_len[s] == held_n)
            begin
                hit = 3'(s);
                return M_EXACT;
            end
            verdict = M_PREFIX;
        end
        return verdict;
    endfunction

    function automatic spot_res_t predict_item(input spot_item_t it);
        spot_res_t  r;
        logic [7:0] c;
        logic [2:0] hit;
        match_t     m;
        int         passes;
        r = '0;
        c = upcase(it.ch);
        case (it.op)
            kss_pkg::OP_CHAR:
            begin
                if (!it.typing)
                begin
                    last_ch = c;
                    // a full string saturates to the too-long mark
                    if (held_n < KEYLEN)
                    begin
                        held[held_n] = c;
                        held_n++;
                    end
                    else
                        held_n = TOO_LONG;
                    // second pass only after a collapse to the newest char
                    passes = spot_en ? 2 : 0;
                    while (passes > 0)
                    begin
                        passes--;
                        m = match_held(hit);
                        if (m == M_EXACT)
                        begin
                            held_n = 0;
                            r.fired = 1'b1;
                            r.slot = hit;
                            passes = 0;
                        end
                        else if (m == M_PREFIX)
                            passes = 0;
                        else if (held_n >= 2)
                        begin
                            held[0] = last_ch;
                            held_n = 1;
                        end
                        else
                        begin
                            held_n = 0;
                            passes = 0;
                        end
                    end
                end
            end
            kss_pkg::OP_TOGGLE:
                if (tog_ok)
                    spot_en = !spot_en;
            kss_pkg::OP_KEY_CHAR:
                if (it.slot < NSLOT && it.pos < KEYLEN)
                    kw_chars[it.slot][it.pos] = c;
            kss_pkg::OP_KEY_LEN:
                if (it.slot < NSLOT)
                    kw_len[it.slot] = (it.klen > KEYLEN) ? 5'(KEYLEN) : it.klen;
            default: ;
        endcase
        r.hlen = 5'(held_n);
        r.on = spot_en;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------
    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_keyword_sequence_spotter failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: new payload and ready at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
            // valid holds with the same payload until the transfer
            if (!in_valid || in_taken)
            begin
                if (spot_pending.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur_item = spot_pending.pop_front();
                    in_valid <= 1'b1;
                    opcode <= cur_item.op;
                    char_code <= cur_item.ch;
                    typing_active <= cur_item.typing;
                    slot <= cur_item.slot;
                    position <= cur_item.pos;
                    keyword_length <= cur_item.klen;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results first, then predict the accepted item
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        spot_res_t want;
        spot_res_t seen;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {fired, fired_slot, held_length, spotting_on};
            if (spot_expected.size() == 0)
            begin
                if (errors < 10)
                    $display("UNEXPECTED result at %0t: fired=%0d slot=%0d held=%0d on=%0d",
                             $time, seen.fired, seen.slot, seen.hlen, seen.on);
                errors++;
            end
            else
            begin
                want = spot_expected.pop_front();
                if (want.fired !== seen.fired || want.slot !== seen.slot ||
                    want.hlen !== seen.hlen || want.on !== seen.on)
                begin
                    // values in order fired/slot/held/on
                    if (errors < 10)
                        $display(
                            "MISMATCH at %0t: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                            $time, want.fired, want.slot, want.hlen, want.on,
                            seen.fired, seen.slot, seen.hlen, seen.on);
                    errors++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            spot_expected.push_back(predict_item(cur_item));
            items_open--;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic spot_item_t rand_item();
        spot_item_t it;
        it.op = kss_pkg::op_t'(2'($urandom_range(3)));
        it.ch = 8'($urandom_range(255));
        it.typing = 1'($urandom_range(1));
        it.slot = 3'($urandom_range(7));
        it.pos = 4'($urandom_range(15));
        it.klen = 5'($urandom_range(31));
        return it;
    endfunction

    // small alphabet in random case, so keywords get typed often
    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = 8'h41 + 8'($urandom_range(2));
        if ($urandom_range(1))
            c = c + 8'h20;
        return c;
    endfunction

    task automatic queue_item(input spot_item_t it);
        spot_pending.push_back(it);
        items_open++;
        // ignored characters do not count toward the run length
        if (!(it.op == kss_pkg::OP_CHAR && it.typing))
            items_made++;
    endtask

    task automatic send_char(input logic [7:0] c, input bit typing);
        spot_item_t it;
        it = rand_item();
        it.op = kss_pkg::OP_CHAR;
        it.ch = c;
        it.typing = typing;
        queue_item(it);
    endtask

    task automatic send_toggle();
        spot_item_t it;
        it = rand_item();
        it.op = kss_pkg::OP_TOGGLE;
        queue_item(it);
    endtask

    task automatic send_key_char(input int s, input int p, input logic [7:0] c);
        spot_item_t it;
        it = rand_item();
        it.op = kss_pkg::OP_KEY_CHAR;
        it.slot = 3'(s);
        it.pos = 4'(p);
        it.ch = c;
        gen_chars[s][p] = upcase(c);
        gen_wr[s][p] = 1'b1;
        queue_item(it);
    endtask

    // n may exceed the max length (saturates) or be zero (empties the slot)
    task automatic send_key_len(input int s, input int n);
        spot_item_t it;
        int         eff;
        eff = (n > KEYLEN) ? KEYLEN : n;
        for (int p = 0; p < eff; p++)
            if (!gen_wr[s][p])
                send_key_char(s, p, pick_letter());
        it = rand_item();
        it.op = kss_pkg::OP_KEY_LEN;
        it.slot = 3'(s);
        it.klen = 5'(n);
        gen_len[s] = eff;
        queue_item(it);
    endtask

    task automatic load_word(input int s, input int n);
        for (int p = 0; p < n && p < KEYLEN; p++)
            send_key_char(s, p, ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                        : pick_letter());
        send_key_len(s, n);
    endtask

    // type a stored keyword in random case, now and then broken by typing mode
    task automatic type_word(input int s);
        logic [7:0] c;
        for (int p = 0; p < gen_len[s]; p++)
        begin
            c = gen_chars[s][p];
            if (c >= "A" && c <= "Z" && $urandom_range(1))
                c = c + 8'h20;
            send_char(c, $urandom_range(99) < 4);
        end
    endtask

    task automatic run_random(input int n);
        int stop;
        int roll;
        int s;
        int k;
        stop = items_made + n;
        while (items_made < stop)
        begin
            roll = $urandom_range(99);
            s = $urandom_range(NSLOT - 1);
            if (roll < 45)
            begin
                if (gen_len[s] == 0)
                    load_word(s, $urandom_range(1, 4));
                else
                begin
                    if ($urandom_range(3) == 0)
                        send_char(pick_letter(), 1'b0);
                    type_word(s);
                end
            end
            else if (roll < 65)
                repeat ($urandom_range(1, 6))
                    send_char(pick_letter(), $urandom_range(99) < 10);
            else if (roll < 73)
                send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
            else if (roll < 77)
                // long runs can reach the too-long mark while spotting is off
                repeat ($urandom_range(15, 20))
                    send_char(pick_letter(), 1'b0);
            else if (roll < 82)
                send_toggle();
            else if (roll < 94)
            begin
                k = $urandom_range(99);
                if (k < 70)
                    load_word(s, $urandom_range(1, 4));
                else if (k < 85)
                    load_word(s, $urandom_range(5, KEYLEN));
                else
                    send_key_len(s, $urandom_range(31));
            end
            else
                send_key_char(s, $urandom_range(KEYLEN - 1), 8'($urandom_range(255)));
        end
    endtask

    // wait until every queued item went in and every result came out
    task automatic drain();
        do
            @(negedge clk);
        while (items_open != 0 || spot_expected.size() != 0);
    endtask

    task automatic write_reg(input kss_pkg::cfg_idx_t idx, input bit val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        // enabled_at_reset also loads the live enable
        if (idx == kss_pkg::CFG_ENABLED_AT_RESET)
        begin
            en_at_reset = val;
            spot_en = val;
        end
        else
            tog_ok = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic start_phase(input bit en, input bit tog, input bit steady);
        drain();
        write_reg(kss_pkg::CFG_ENABLED_AT_RESET, en);
        write_reg(kss_pkg::CFG_TOGGLE_ALLOWED, tog);
        no_gaps <= steady;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int s = 0; s < NSLOT; s++)
        begin
            kw_len[s] = '0;
            gen_len[s] = 0;
            for (int p = 0; p < KEYLEN; p++)
                gen_wr[s][p] = 1'b0;
        end
        held_n = 0;
        spot_en = 1'b0;
        en_at_reset = 1'b0;
        tog_ok = 1'b0;
        last_ch = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: toggle refused, typing mode ignored, chars pile up
        send_toggle();
        send_char("x", 1'b1);
        send_char("q", 1'b0);
        drain();
        write_reg(kss_pkg::CFG_TOGGLE_ALLOWED, 1'b1);

        // same keyword in slots 0 and 3: the lower slot wins
        send_key_char(0, 0, "a");
        send_key_char(0, 1, "B");
        send_key_len(0, 2);
        send_key_char(3, 0, "A");
        send_key_char(3, 1, "b");
        send_key_len(3, 2);
        send_toggle();
        // "QA" collapses to a live prefix "A", then "AB" fires
        send_char("A", 1'b0);
        send_char("b", 1'b0);
        send_char("z", 1'b0);
        send_char("a", 1'b0);
        send_char("a", 1'b0);
        send_char("B", 1'b0);
        // emptying slot 0 leaves slot 3 to fire
        send_key_len(0, 0);
        send_char("a", 1'b0);
        send_char("b", 1'b0);
        send_key_len(3, 0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_toggle();
        start_phase(1'b1, 1'b0, 1'b0);
        send_toggle();
        send_char("a", 1'b0);

        // random part over the register settings, one phase without idling
        start_phase(1'b1, 1'b1, 1'b0);
        run_random(400);
        start_phase(1'b0, 1'b0, 1'b0);
        run_random(200);
        start_phase(1'b1, 1'b0, 1'b1);
        run_random(400);
        start_phase(1'b0, 1'b1, 1'b0);
        run_random(400);
        start_phase(1'b1, 1'b1, 1'b0);
        run_random(350);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0 && spot_expected.size() == 0)
            $display("tb_keyword_sequence_spotter passed");
        else
            $display("tb_keyword_sequence_spotter failed");
        $finish;
    end

endmodule
